// File: rtl/ibc_pkg.sv
`timescale 1ns / 1ps

package ibc_pkg;

  // Sizing of the block.
  localparam int BANDS       = 3;
  localparam int INDEX_BITS  = 16;
  localparam int SAMPLE_BITS = 32;
  localparam int ACC_BITS    = 48;

  // Fixed widths of the interface fields.
  localparam int IN_BANDS    = 3;
  localparam int KIND_BITS   = 2;
  localparam int FIELD_INDEX = 16;
  localparam int FIELD_SAMP  = 32;
  localparam int MODE_BITS   = 2;
  localparam int CFG_DATA    = 2;
  localparam int CFG_ADDR    = 1;

  localparam int STORE_BANDS = (BANDS < IN_BANDS) ? BANDS : IN_BANDS;
  localparam int ROW_BITS    = STORE_BANDS * ACC_BITS + 1;
  localparam int NBINS       = 1 << INDEX_BITS;

  // Item kinds.
  localparam logic [KIND_BITS-1:0] KIND_ACC     = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_READ    = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_RESTART = 2'd2;

  // Combine modes.
  localparam logic [MODE_BITS-1:0] MODE_SUM = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_MAX = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_MIN = 2'd2;

  // Register indexes.
  localparam logic [CFG_ADDR-1:0] REG_COMBINE_MODE = 1'd0;
  localparam logic [CFG_ADDR-1:0] REG_INDEX_WIDE   = 1'd1;

  localparam logic [FIELD_INDEX-1:0] NARROW_HIGHEST = 16'd255;

  localparam logic signed [63:0] ACC_MAX64 = (64'sd1 <<< (ACC_BITS - 1)) - 64'sd1;
  localparam logic signed [63:0] ACC_MIN64 = -ACC_MAX64 - 64'sd1;
  localparam logic signed [ACC_BITS-1:0] ACC_MAX = ACC_BITS'(ACC_MAX64);
  localparam logic signed [ACC_BITS-1:0] ACC_MIN = ACC_BITS'(ACC_MIN64);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } ctl_state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic clear;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
  } dp_status_t;

  // Takes the low sample bits as a signed value and clamps it to the
  // accumulator range.
  function automatic logic signed [ACC_BITS-1:0] to_acc(input logic [FIELD_SAMP-1:0] raw);
    logic signed [63:0] ext;
    logic signed [63:0] clamped;
    ext = 64'(signed'(raw[SAMPLE_BITS-1:0]));
    if (ext > ACC_MAX64) begin
      clamped = ACC_MAX64;
    end else if (ext < ACC_MIN64) begin
      clamped = ACC_MIN64;
    end else begin
      clamped = ext;
    end
    return ACC_BITS'(clamped);
  endfunction

  function automatic logic signed [ACC_BITS-1:0] sat_add(
    input logic signed [ACC_BITS-1:0] a,
    input logic signed [ACC_BITS-1:0] b
  );
    logic signed [ACC_BITS:0] sum;
    sum = {a[ACC_BITS-1], a} + {b[ACC_BITS-1], b};
    if (sum[ACC_BITS] != sum[ACC_BITS-1]) begin
      return sum[ACC_BITS] ? ACC_MIN : ACC_MAX;
    end
    return sum[ACC_BITS-1:0];
  endfunction

endpackage

// File: rtl/ibc_ctrl.sv
`timescale 1ns / 1ps

module ibc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  ibc_pkg::dp_status_t status,
  output ibc_pkg::dp_cmd_t   cmd,
  output logic               busy
);
  import ibc_pkg::*;

  ctl_state_t state;
  ctl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    busy        = 1'b1;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    cmd.clear   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
      end
      ST_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// File: rtl/ibc_datapath.sv
`timescale 1ns / 1ps

module ibc_datapath (
  input  logic                                   clk,
  input  logic                                   rst,
  input  ibc_pkg::dp_cmd_t                       cmd,
  output ibc_pkg::dp_status_t                    status,
  input  logic                                   cfg_write,
  input  logic [ibc_pkg::CFG_ADDR-1:0]           cfg_index,
  input  logic [ibc_pkg::CFG_DATA-1:0]           cfg_data,
  input  logic [ibc_pkg::KIND_BITS-1:0]          kind,
  input  logic [ibc_pkg::FIELD_INDEX-1:0]        bin_index,
  input  logic signed [ibc_pkg::FIELD_SAMP-1:0]  sample_a,
  input  logic signed [ibc_pkg::FIELD_SAMP-1:0]  sample_b,
  input  logic signed [ibc_pkg::FIELD_SAMP-1:0]  sample_c,
  output logic signed [ibc_pkg::ACC_BITS-1:0]    value_a,
  output logic signed [ibc_pkg::ACC_BITS-1:0]    value_b,
  output logic signed [ibc_pkg::ACC_BITS-1:0]    value_c,
  output logic                                   bin_used,
  output logic [ibc_pkg::FIELD_INDEX-1:0]        highest_seen,
  output logic                                   done
);
  import ibc_pkg::*;

  // Bin store: one row per bin, the used flag in the top bit.
  logic [ROW_BITS-1:0] mem [NBINS];
  logic [ROW_BITS-1:0] rdata;
  logic [ROW_BITS-1:0] wdata;
  logic                wr_en;

  logic [MODE_BITS-1:0]   combine_mode;
  logic                   index_wide;
  logic [INDEX_BITS-1:0]  clr_cnt;
  logic [FIELD_INDEX-1:0] highest_index;

  logic [KIND_BITS-1:0]         kind_q;
  logic [INDEX_BITS-1:0]        addr_q;
  logic [INDEX_BITS-1:0]        addr_in;
  logic signed [ACC_BITS-1:0]   samp_q [IN_BANDS];
  logic signed [ACC_BITS-1:0]   old_v  [IN_BANDS];
  logic signed [ACC_BITS-1:0]   new_v  [STORE_BANDS];
  logic signed [ACC_BITS-1:0]   out_v  [IN_BANDS];
  logic                         old_used;

  assign status.clear_last = (clr_cnt == {INDEX_BITS{1'b1}});
  assign addr_in = index_wide ? bin_index[INDEX_BITS-1:0] : INDEX_BITS'(bin_index[7:0]);
  assign old_used = rdata[ROW_BITS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      combine_mode <= MODE_SUM;
      index_wide   <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_COMBINE_MODE: combine_mode <= cfg_data[MODE_BITS-1:0];
        REG_INDEX_WIDE:   index_wide   <= cfg_data[0];
        default:          index_wide   <= index_wide;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + INDEX_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_q    <= kind;
      addr_q    <= addr_in;
      samp_q[0] <= to_acc(sample_a);
      samp_q[1] <= to_acc(sample_b);
      samp_q[2] <= to_acc(sample_c);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rdata <= mem[addr_in];
    end
    if (cmd.clear) begin
      mem[clr_cnt] <= '0;
    end else if (wr_en) begin
      mem[addr_q] <= wdata;
    end
  end

  for (genvar k = 0; k < IN_BANDS; k++) begin : g_old
    if (k < STORE_BANDS) begin : g_stored
      assign old_v[k] = rdata[k*ACC_BITS +: ACC_BITS];
    end else begin : g_absent
      assign old_v[k] = '0;
    end
  end

  always_comb begin
    for (int k = 0; k < STORE_BANDS; k++) begin
      if (!old_used) begin
        new_v[k] = samp_q[k];
      end else begin
        unique case (combine_mode)
          MODE_MAX: new_v[k] = (samp_q[k] > old_v[k]) ? samp_q[k] : old_v[k];
          MODE_MIN: new_v[k] = (samp_q[k] < old_v[k]) ? samp_q[k] : old_v[k];
          default:  new_v[k] = sat_add(old_v[k], samp_q[k]);
        endcase
      end
    end
  end

  always_comb begin
    wdata = '0;
    wr_en = 1'b0;
    if (cmd.exec && kind_q == KIND_ACC) begin
      wr_en = 1'b1;
      wdata[ROW_BITS-1] = 1'b1;
      for (int k = 0; k < STORE_BANDS; k++) begin
        wdata[k*ACC_BITS +: ACC_BITS] = new_v[k];
      end
    end else if (cmd.exec && kind_q == KIND_READ) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      highest_index <= '0;
    end else if (cmd.exec) begin
      if (kind_q == KIND_ACC) begin
        if (!index_wide) begin
          highest_index <= NARROW_HIGHEST;
        end else if (FIELD_INDEX'(addr_q) > highest_index) begin
          highest_index <= FIELD_INDEX'(addr_q);
        end
      end else if (kind_q == KIND_RESTART) begin
        highest_index <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.exec && (kind_q == KIND_READ);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && kind_q == KIND_READ) begin
      for (int k = 0; k < IN_BANDS; k++) begin
        out_v[k] <= old_used ? old_v[k] : '0;
      end
      bin_used     <= old_used;
      highest_seen <= highest_index;
    end
  end

  assign value_a = out_v[0];
  assign value_b = out_v[1];
  assign value_c = out_v[2];

endmodule

// File: rtl/indexed_bin_combiner.sv
`timescale 1ns / 1ps
// A read item's result is registered onto the result ports, with done high, at the end of
// the execute state that follows its acceptance; other items give no result.
// No new item is taken during the execute cycle, in which busy is high and the bin row read at
// acceptance is combined and written back through the single port.
// Reset: a synchronous rst starts a clearing pass that zeroes each of the 2^INDEX_BITS (65536)
// bin rows in turn; busy is high throughout and configuration writes are still taken.
// The receiver cannot stall: done is high for exactly one cycle per read result.

module indexed_bin_combiner (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [ibc_pkg::CFG_ADDR-1:0]           cfg_index,
  input  logic [ibc_pkg::CFG_DATA-1:0]           cfg_data,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [ibc_pkg::KIND_BITS-1:0]          kind,
  input  logic [ibc_pkg::FIELD_INDEX-1:0]        bin_index,
  input  logic signed [ibc_pkg::FIELD_SAMP-1:0]  sample_a,
  input  logic signed [ibc_pkg::FIELD_SAMP-1:0]  sample_b,
  input  logic signed [ibc_pkg::FIELD_SAMP-1:0]  sample_c,
  output logic                                   done,
  output logic signed [ibc_pkg::ACC_BITS-1:0]    value_a,
  output logic signed [ibc_pkg::ACC_BITS-1:0]    value_b,
  output logic signed [ibc_pkg::ACC_BITS-1:0]    value_c,
  output logic                                   bin_used,
  output logic [ibc_pkg::FIELD_INDEX-1:0]        highest_seen
);
  import ibc_pkg::*;

  // The controller sequences clearing, acceptance and the execute cycle; the datapath
  // holds the bin memory, the registers and the combine arithmetic.
  dp_cmd_t    cmd;
  dp_status_t status;

  ibc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // A read item returns the bin as it stood and leaves it unused; the stored values of an
  // unused bin are never looked at, since the next pixel overwrites them.
  ibc_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .kind         (kind),
    .bin_index    (bin_index),
    .sample_a     (sample_a),
    .sample_b     (sample_b),
    .sample_c     (sample_c),
    .value_a      (value_a),
    .value_b      (value_b),
    .value_c      (value_c),
    .bin_used     (bin_used),
    .highest_seen (highest_seen),
    .done         (done)
  );

endmodule
